@@ rtl/aabb_pkg.sv @@
// Shared types and constants for the box contact generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package aabb_pkg;
   localparam int MaxBoxesDef = 8;
   localparam int IdxW = 3;
   localparam int CntW = 5;
   localparam int CoordW = 32;
   localparam int SizeW = 31;
   localparam int EdgeW = 33;

   typedef struct packed {
      logic signed [CoordW-1:0] left;
      logic signed [CoordW-1:0] top;
      logic [SizeW-1:0]         wid;
      logic [SizeW-1:0]         hgt;
      logic signed [CoordW-1:0] rx;
      logic signed [CoordW-1:0] ry;
   } box_type;

   // One scan job handed from the front to the back.
   typedef struct packed {
      logic            is_end;
      logic [IdxW-1:0] idx_i;
      logic [IdxW-1:0] idx_j;
      box_type         box_i;
      box_type         box_j;
   } job_type;

   typedef struct packed {
      logic             record_kind;
      logic [IdxW-1:0]  first_box;
      logic [IdxW-1:0]  second_box;
      logic             normal_axis;
      logic signed [1:0] normal_sign;
      logic [SizeW-1:0] depth;
      logic [CntW-1:0]  contact_count;
      logic             last_result;
   } rec_type;
endpackage
`default_nettype wire

@@ rtl/aabb_front.sv @@
// Front end: box store, loading and pair sequencing into job words.
// Depends on aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aabb_front #(
   parameter int MAX_BOXES = aabb_pkg::MaxBoxesDef
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  aabb_pkg::box_type    in_box,
   input  wire                  in_last,
   output logic                 job_valid,
   input  wire                  job_ready,
   output aabb_pkg::job_type    job
);
   import aabb_pkg::*;

   localparam logic [1:0] StLoad = 2'd0;
   localparam logic [1:0] StRead = 2'd1;
   localparam logic [1:0] StEmit = 2'd2;
   localparam logic [1:0] StEnd  = 2'd3;

   box_type mem [MAX_BOXES];
   logic [1:0]      state_ff, state_in;
   logic [IdxW:0]   cnt_ff, cnt_in;
   logic [IdxW-1:0] i_ff, i_in, j_ff, j_in;
   box_type         bi_ff, bj_ff;
   logic            wr;

   assign in_ready = (state_ff == StLoad);
   assign wr = in_valid && in_ready && (cnt_ff < (IdxW+1)'(MAX_BOXES));

   always_ff @(posedge clock) begin
      if (wr) begin
         mem[cnt_ff[IdxW-1:0]] <= in_box;
      end
      bi_ff <= mem[i_ff];
      bj_ff <= mem[j_ff];
   end

   assign job_valid = (state_ff == StEmit) || (state_ff == StEnd);
   always_comb begin
      job.is_end = (state_ff == StEnd);
      job.idx_i  = i_ff;
      job.idx_j  = j_ff;
      job.box_i  = bi_ff;
      job.box_j  = bj_ff;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      unique case (state_ff)
         StLoad: begin
            if (in_valid) begin
               cnt_in = wr ? cnt_ff + 1'b1 : cnt_ff;
               if (in_last) begin
                  i_in = '0;
                  j_in = IdxW'(1);
                  if ({1'b0, cnt_in} < (IdxW+2)'(2)) begin
                     state_in = StEnd;
                  end else begin
                     state_in = StRead;
                  end
               end
            end
         end
         StRead: state_in = StEmit;
         StEmit: begin
            if (job_ready) begin
               state_in = StRead;
               if ({1'b0, j_ff} + 1'b1 < {1'b0, cnt_ff}) begin
                  j_in = j_ff + 1'b1;
               end else if ({1'b0, i_ff} + 2'd2 < {1'b0, cnt_ff}) begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + 2'd2;
               end else begin
                  state_in = StEnd;
               end
            end
         end
         StEnd: begin
            if (job_ready) begin
               state_in = StLoad;
               cnt_in   = '0;
            end
         end
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         cnt_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StEmit) |-> (i_ff < j_ff))
      else $error("pair order broken");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (IdxW+1)'(MAX_BOXES))
      else $error("store overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRead) |=> (state_ff == StEmit))
      else $error("read not followed by emit");
endmodule
`default_nettype wire

@@ rtl/aabb_fifo.sv @@
// Two-entry job queue between front and back.
// Depends on aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aabb_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                wr_valid,
   output logic               wr_ready,
   input  aabb_pkg::job_type  wr_data,
   output logic               rd_valid,
   input  wire                rd_ready,
   output aabb_pkg::job_type  rd_data
);
   import aabb_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

@@ rtl/aabb_back.sv @@
// Back end: overlap test, contact record build and output register.
// Depends on aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aabb_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                job_valid,
   output logic               job_ready,
   input  aabb_pkg::job_type  job,
   output logic               out_valid,
   input  wire                out_ready,
   output aabb_pkg::rec_type  out_rec
);
   import aabb_pkg::*;

   // Stage 1 registers: intersection width and height and reference offsets.
   logic                     s1_v_ff, s1_end_ff;
   logic [IdxW-1:0]          s1_i_ff, s1_j_ff;
   logic signed [EdgeW:0]    s1_w_ff, s1_h_ff;
   logic signed [CoordW:0]   s1_dx_ff, s1_dy_ff;
   logic                     s1_go;
   logic signed [EdgeW-1:0]  ri, rj, bi, bj, il, it, ir, ib;
   logic signed [CoordW-1:0] li, lj, ti, tj;

   logic [CntW-1:0] count_ff;
   rec_type         rec_ff;
   logic            ov_ff;
   logic            s1_move;

   assign s1_move   = s1_v_ff && (!ov_ff || out_ready);
   assign job_ready = !s1_v_ff || s1_move;
   assign s1_go     = job_valid && job_ready;

   always_comb begin
      li = job.box_i.left; lj = job.box_j.left;
      ti = job.box_i.top;  tj = job.box_j.top;
      ri = EdgeW'(li) + $signed({2'b0, job.box_i.wid});
      rj = EdgeW'(lj) + $signed({2'b0, job.box_j.wid});
      bi = EdgeW'(ti) + $signed({2'b0, job.box_i.hgt});
      bj = EdgeW'(tj) + $signed({2'b0, job.box_j.hgt});
      il = (li > lj) ? EdgeW'(li) : EdgeW'(lj);
      it = (ti > tj) ? EdgeW'(ti) : EdgeW'(tj);
      ir = (ri < rj) ? ri : rj;
      ib = (bi < bj) ? bi : bj;
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s1_end_ff <= job.is_end;
         s1_i_ff   <= job.idx_i;
         s1_j_ff   <= job.idx_j;
         s1_w_ff   <= (EdgeW+1)'(ir) - (EdgeW+1)'(il);
         s1_h_ff   <= (EdgeW+1)'(ib) - (EdgeW+1)'(it);
         s1_dx_ff  <= (CoordW+1)'(job.box_i.rx) - (CoordW+1)'(job.box_j.rx);
         s1_dy_ff  <= (CoordW+1)'(job.box_i.ry) - (CoordW+1)'(job.box_j.ry);
      end
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_go) begin
         s1_v_ff <= 1'b1;
      end else if (s1_move) begin
         s1_v_ff <= 1'b0;
      end
   end

   // Stage 2: classify and build the record.
   logic                   hit, ax;
   logic signed [CoordW:0] df;
   rec_type                nrec;
   always_comb begin
      hit = (s1_w_ff > 0) && (s1_h_ff > 0);
      ax  = !(s1_w_ff <= s1_h_ff);
      df  = ax ? s1_dy_ff : s1_dx_ff;
      nrec = '0;
      if (s1_end_ff) begin
         nrec.record_kind   = 1'b1;
         nrec.contact_count = count_ff;
         nrec.last_result   = 1'b1;
      end else begin
         nrec.first_box   = s1_i_ff;
         nrec.second_box  = s1_j_ff;
         nrec.normal_axis = ax;
         nrec.normal_sign = (df > 0) ? 2'sd1 : ((df < 0) ? -2'sd1 : 2'sd0);
         nrec.depth       = ax ? s1_h_ff[SizeW-1:0] : s1_w_ff[SizeW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rec_ff <= nrec;
      end
      if (reset) begin
         ov_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (s1_move) begin
            ov_ff <= s1_end_ff || hit;
            if (s1_end_ff) count_ff <= '0;
            else if (hit)  count_ff <= count_ff + 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_rec   = rec_ff;

   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> $stable(rec_ff))
      else $error("record changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rec_ff.record_kind) |-> (rec_ff.first_box == '0))
      else $error("end record carries a box");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(28))
      else $error("contact count overflow");
endmodule
`default_nettype wire

@@ rtl/aabb_contact_generator_core.sv @@
// Top level of the box contact generator: front, job queue and back.
// Depends on aabb_pkg, aabb_front, aabb_fifo and aabb_back.
//
// Usage: send one box per req word. tdata holds, from bit 0 up, box_left,
// box_top, box_width, box_height, ref_x and ref_y; tlast marks the last box.
// Boxes load at one word per cycle. The store holds MAX_BOXES boxes; extra
// boxes are dropped. After the box with tlast, the front reads each pair
// i<j from the store and queues it; the back tests the overlap and sends a
// contact word on rsp for each overlapping pair, then an end word with
// tuser high carrying the contact count and tlast high.
// The front reads each pair from the store ahead of its job and moves on to
// the next pair once that job is taken; eight boxes give a set of 28 pairs.
// While the scan runs, req_tready is low. When rsp stalls, the back holds
// its word, the queue fills and the front waits; nothing is lost.
// Reset (synchronous, active high) empties the store and the queue.
`timescale 1ns / 1ps
`default_nettype none
module aabb_contact_generator_core #(
   parameter int MAX_BOXES = aabb_pkg::MaxBoxesDef
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // box_left, box_top, box_width, box_height, ref_x, ref_y; zero pad
   input  wire  [191:0] req_tdata,
   input  wire          req_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // first_box, second_box, normal_axis, normal_sign, depth, contact_count;
   // zero pad
   output logic [47:0]  rsp_tdata,
   // record_kind
   output logic         rsp_tuser,
   output logic         rsp_tlast
);
   import aabb_pkg::*;

   box_type in_box;
   job_type f_job, q_job;
   logic    f_valid, f_ready, q_valid, q_ready;
   rec_type rec;

   // Unpack the request word into a box.
   always_comb begin
      in_box.left = req_tdata[31:0];
      in_box.top  = req_tdata[63:32];
      in_box.wid  = req_tdata[94:64];
      in_box.hgt  = req_tdata[125:95];
      in_box.rx   = req_tdata[157:126];
      in_box.ry   = req_tdata[189:158];
   end

   aabb_front #(.MAX_BOXES(MAX_BOXES)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_box(in_box), .in_last(req_tlast),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   aabb_fifo u_fifo (
      .clock(clock), .reset(reset),
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
   );

   aabb_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rec(rec)
   );

   assign rsp_tuser = rec.record_kind;
   assign rsp_tlast = rec.last_result;
   assign rsp_tdata = {3'b0, rec.contact_count, rec.depth, rec.normal_sign,
                       rec.normal_axis, rec.second_box, rec.first_box};
endmodule
`default_nettype wire

@@ sim/aabb_contact_generator_core_tb.sv @@
// Testbench for the box contact generator: drives box sets on req and checks
// contact and end words on rsp against a scoreboard that scans the pairs itself.
// Depends on aabb_pkg and aabb_contact_generator_core.
`timescale 1ns / 1ps

class contact_board;
   aabb_pkg::rec_type pending[$];
   longint l[8], t[8], w[8], h[8], px[8], py[8];
   int unsigned loaded;
   int errors;

   function new();
      loaded = 0;
      errors = 0;
   endfunction

   // Stores one box and, on the closing box, queues every contact of the set.
   function void note_box(logic [191:0] data, logic closing);
      aabb_pkg::rec_type r;
      longint il, it, ir, ib, ow, oh, diff;
      int unsigned count;
      count = 0;
      if (loaded < 8) begin
         l[loaded] = longint'($signed(data[31:0]));
         t[loaded] = longint'($signed(data[63:32]));
         w[loaded] = longint'(data[94:64]);
         h[loaded] = longint'(data[125:95]);
         px[loaded] = longint'($signed(data[157:126]));
         py[loaded] = longint'($signed(data[189:158]));
         loaded++;
      end
      if (!closing) return;
      for (int i = 0; i < loaded; i++) begin
         for (int j = i + 1; j < loaded; j++) begin
            il = (l[i] > l[j]) ? l[i] : l[j];
            it = (t[i] > t[j]) ? t[i] : t[j];
            ir = (l[i] + w[i] < l[j] + w[j]) ? l[i] + w[i] : l[j] + w[j];
            ib = (t[i] + h[i] < t[j] + h[j]) ? t[i] + h[i] : t[j] + h[j];
            if (!(il < ir && it < ib)) continue;
            ow = ir - il;
            oh = ib - it;
            r = '0;
            r.first_box = 3'(i);
            r.second_box = 3'(j);
            if (ow <= oh) begin
               r.normal_axis = 1'b0;
               r.depth = ow[30:0];
               diff = px[i] - px[j];
            end else begin
               r.normal_axis = 1'b1;
               r.depth = oh[30:0];
               diff = py[i] - py[j];
            end
            r.normal_sign = (diff > 0) ? 2'sd1 : ((diff < 0) ? -2'sd1 : 2'sd0);
            pending = {pending, r};
            count++;
         end
      end
      r = '0;
      r.record_kind = 1'b1;
      r.contact_count = count[4:0];
      r.last_result = 1'b1;
      pending = {pending, r};
      loaded = 0;
   endfunction

   function void check_word(logic [47:0] data, logic kind, logic last);
      aabb_pkg::rec_type e;
      if (pending.size() == 0) begin
         $error("unexpected word %h kind %b", data, kind);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (kind !== e.record_kind) begin
         $error("record_kind exp %0d got %0d", e.record_kind, kind); errors++;
      end
      if (data[2:0] !== e.first_box) begin
         $error("first_box exp %0d got %0d", e.first_box, data[2:0]); errors++;
      end
      if (data[5:3] !== e.second_box) begin
         $error("second_box exp %0d got %0d", e.second_box, data[5:3]); errors++;
      end
      if (data[6] !== e.normal_axis) begin
         $error("normal_axis exp %0d got %0d", e.normal_axis, data[6]); errors++;
      end
      if (data[8:7] !== e.normal_sign) begin
         $error("normal_sign exp %0d got %0d", e.normal_sign, $signed(data[8:7])); errors++;
      end
      if (data[39:9] !== e.depth) begin
         $error("depth exp %h got %h", e.depth, data[39:9]); errors++;
      end
      if (data[44:40] !== e.contact_count) begin
         $error("contact_count exp %0d got %0d", e.contact_count, data[44:40]); errors++;
      end
      if (last !== e.last_result) begin
         $error("last_result exp %0d got %0d", e.last_result, last); errors++;
      end
   endfunction
endclass

module aabb_contact_generator_core_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [191:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   contact_board board = new();
   int send_idle = 23;
   int recv_idle = 56;
   bit hold_off = 1'b0;
   longint cycles = 0;
   int sent = 0;

   always #6 clock = ~clock;

   aabb_contact_generator_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("[aabb_contact_generator_core] ERROR");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) board.note_box(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // The receiver stalls at random, or for a long stretch while hold_off is set.
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // Offers one box and waits until it is taken. tvalid stays high after the
   // handshake so that a following box can go out without a gap; idling and
   // drain() take it low.
   task automatic send_box(logic signed [31:0] lft, logic signed [31:0] top,
                           logic [30:0] wid, logic [30:0] hgt,
                           logic signed [31:0] rx, logic signed [31:0] ry, logic closing);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {2'b0, ry, rx, hgt, wid, top, lft};
      req_tlast <= closing;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // Boxes drawn from a small field so that many pairs overlap; now and
   // then a wide range value exercises every bit.
   task automatic random_set(int count);
      logic signed [31:0] lft, top, rx, ry;
      logic [30:0] wid, hgt;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(9) == 0) begin
            lft = $urandom; top = $urandom; wid = 31'($urandom); hgt = 31'($urandom);
            rx = $urandom; ry = $urandom;
         end else begin
            lft = $signed($urandom_range(400)) - 200;
            top = $signed($urandom_range(400)) - 200;
            wid = 31'($urandom_range(200)); hgt = 31'($urandom_range(200));
            rx = $urandom_range(3); ry = $urandom_range(3);
         end
         send_box(lft, top, wid, hgt, rx, ry, k == count - 1);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: extremes, touching edges, equal positions, a single box.
      send_box(32'sh80000000, 32'sh80000000, 31'h7fffffff, 31'h7fffffff,
               32'sh7fffffff, 32'sh80000000, 1'b0);
      send_box(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff,
               32'sh80000000, 32'sh7fffffff, 1'b0);
      send_box(0, 0, 31'h7fffffff, 31'h7fffffff, 0, 0, 1'b0);
      send_box(10, 0, 5, 0, 1, 1, 1'b1);
      send_box(0, 0, 10, 10, 5, 5, 1'b0);
      send_box(10, 0, 10, 10, 1, 1, 1'b0);
      send_box(5, 2, 10, 4, 5, 9, 1'b0);
      send_box(2, 5, 4, 10, 5, 5, 1'b1);
      send_box(3, 3, 1, 1, 0, 0, 1'b1);
      for (int k = 0; k < 10; k++) send_box(0, 0, 20, 20, k, -k, k == 9);
      drain();
      // Long receiver hold-off so the queue fills and the input stalls.
      hold_off = 1'b1;
      fork
         begin repeat (300) @(negedge clock); hold_off = 1'b0; end
         begin random_set(8); random_set(8); end
      join
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin send_idle = 56; recv_idle = 23; end
         if (phase == 2) begin send_idle = 0; recv_idle = 0; end
         while (sent < 35 + 100 * (phase + 1)) random_set($urandom_range(1, 9));
         drain();
      end
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[aabb_contact_generator_core] OK");
      else
         $display("[aabb_contact_generator_core] ERROR");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/aabb_pkg.sv
rtl/aabb_front.sv
rtl/aabb_fifo.sv
rtl/aabb_back.sv
rtl/aabb_contact_generator_core.sv
sim/aabb_contact_generator_core_tb.sv
